// File: rtl/ple_pkg.sv
// shared types and constants of the positional list engine
package ple_pkg;

	localparam int REQ_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD_FIRST    = 3'd0,
		REQ_ADD_LAST     = 3'd1,
		REQ_ADD_AT       = 3'd2,
		REQ_REMOVE_FIRST = 3'd3,
		REQ_REMOVE_LAST  = 3'd4,
		REQ_REMOVE_AT    = 3'd5,
		REQ_CLEAR        = 3'd6,
		REQ_DUMP         = 3'd7
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADIDX = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INSERT,
		OP_REMOVE,
		OP_ROTATE,
		OP_CLEAR
	} op_t;

	// command from the controller to the datapath
	typedef struct packed {
		op_t              op;
		logic [POS_W-1:0] idx;
		logic             load;
		status_t          status;
		logic             item_valid;
		logic             last;
	} cmd_t;

endpackage

// File: rtl/ple_ctrl.sv
// request decoder and sequencer of the positional list engine
module ple_ctrl #(
	parameter int CAPACITY = 16,
	parameter int CW       = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  ple_pkg::req_t                 req,
	input  logic [ple_pkg::POS_W-1:0]     position,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [CW-1:0]                 count,
	output ple_pkg::cmd_t                 cmd
);
	import ple_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t          state_q;
	logic            m_valid_q;
	logic [CW-1:0]   rem_q;

	logic             out_free;
	logic             accept;
	logic             dump_start;
	logic             is_empty;
	logic             is_full;
	logic             bad_pos;
	logic [POS_W-1:0] n_ext;
	logic [POS_W-1:0] last_idx;

	assign n_ext    = POS_W'(count);
	assign last_idx = n_ext - POS_W'(1);
	assign is_empty = (count == '0);
	assign is_full  = (count == CW'(CAPACITY));
	assign bad_pos  = (position >= n_ext);
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.op         = OP_NONE;
		cmd.status     = ST_OK;
		cmd.last       = 1'b1;
		dump_start     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					unique case (req)
						REQ_ADD_FIRST: begin
							if (is_full) cmd.status = ST_FULL;
							else cmd.op = OP_INSERT;
						end
						REQ_ADD_LAST: begin
							if (is_full) cmd.status = ST_FULL;
							else begin
								cmd.op  = OP_INSERT;
								cmd.idx = n_ext;
							end
						end
						REQ_ADD_AT: begin
							if (is_empty) cmd.status = ST_EMPTY;
							else if (bad_pos) cmd.status = ST_BADIDX;
							else if (is_full) cmd.status = ST_FULL;
							else begin
								cmd.op  = OP_INSERT;
								// the front position wins, the back position appends after the
								// last entry
								if (position == '0) cmd.idx = '0;
								else if (position == last_idx) cmd.idx = n_ext;
								else cmd.idx = position;
							end
						end
						REQ_REMOVE_FIRST: begin
							if (is_empty) cmd.status = ST_EMPTY;
							else cmd.op = OP_REMOVE;
						end
						REQ_REMOVE_LAST: begin
							if (is_empty) cmd.status = ST_EMPTY;
							else begin
								cmd.op  = OP_REMOVE;
								cmd.idx = last_idx;
							end
						end
						REQ_REMOVE_AT: begin
							if (is_empty) cmd.status = ST_EMPTY;
							else if (bad_pos) cmd.status = ST_BADIDX;
							else begin
								cmd.op  = OP_REMOVE;
								cmd.idx = position;
							end
						end
						REQ_CLEAR: cmd.op = OP_CLEAR;
						REQ_DUMP: begin
							if (is_empty) cmd.status = ST_EMPTY;
							else begin
								cmd.load   = 1'b0;
								dump_start = 1'b1;
							end
						end
						default: cmd.load = 1'b0;
					endcase
				end
			end
			S_DUMP: begin
				if (out_free) begin
					cmd.load       = 1'b1;
					cmd.op         = OP_ROTATE;
					cmd.item_valid = 1'b1;
					cmd.last       = (rem_q == CW'(1));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			rem_q     <= '0;
		end else begin
			if (cmd.load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (dump_start) begin
						state_q <= S_DUMP;
						rem_q   <= count;
					end
				end
				S_DUMP: begin
					if (cmd.load) begin
						rem_q <= rem_q - CW'(1);
						if (rem_q == CW'(1)) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> !s_tready)
		else $error("input taken during dump");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!m_valid_q || m_tready))
		else $error("pending result overwritten");

	a_dump_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> ((rem_q != '0) && (rem_q <= count)))
		else $error("dump counter out of range");

endmodule

// File: rtl/ple_dpath.sv
// entry cell chain, entry count and result register of the positional list engine
module ple_dpath #(
	parameter int CAPACITY = 16,
	parameter int CW       = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ple_pkg::cmd_t                       cmd,
	input  logic signed [ple_pkg::VALUE_W-1:0]  value,
	output logic [CW-1:0]                       count,
	output ple_pkg::status_t                    out_status,
	output logic [ple_pkg::COUNT_W-1:0]         out_count,
	output logic signed [ple_pkg::VALUE_W-1:0]  out_data,
	output logic                                out_item_valid,
	output logic                                out_last
);
	import ple_pkg::*;

	logic signed [VALUE_W-1:0] cells_q [CAPACITY];
	logic signed [VALUE_W-1:0] cells_d [CAPACITY];
	logic signed [VALUE_W-1:0] prev_w  [CAPACITY];
	logic signed [VALUE_W-1:0] next_w  [CAPACITY];
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_d;
	logic [CW-1:0]             idx;
	logic [CW-1:0]             tail;

	status_t                   status_q;
	logic [COUNT_W-1:0]        ocount_q;
	logic signed [VALUE_W-1:0] odata_q;
	logic                      ovalid_q;
	logic                      olast_q;

	assign idx   = cmd.idx[CW-1:0];
	assign tail  = count_q - CW'(1);
	assign count = count_q;

	// neighbor taps of each cell
	for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
		if (g == 0) begin : g_first
			assign prev_w[g] = cells_q[0];
		end else begin : g_prev
			assign prev_w[g] = cells_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_end
			assign next_w[g] = cells_q[g];
		end else begin : g_next
			assign next_w[g] = cells_q[g+1];
		end
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cells_d[i] = cells_q[i];
			case (cmd.op)
				OP_INSERT: begin
					if (CW'(i) == idx) cells_d[i] = value;
					else if (CW'(i) > idx) cells_d[i] = prev_w[i];
				end
				OP_REMOVE: begin
					if (CW'(i) >= idx) cells_d[i] = next_w[i];
				end
				OP_ROTATE: begin
					// front entry wraps to the back of the occupied part
					if (CW'(i) < tail) cells_d[i] = next_w[i];
					else if (CW'(i) == tail) cells_d[i] = cells_q[0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.op)
			OP_INSERT: count_d = count_q + CW'(1);
			OP_REMOVE: count_d = count_q - CW'(1);
			OP_CLEAR:  count_d = '0;
			default:   count_d = count_q;
		endcase
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			cells_q[i] <= cells_d[i];
		end
		if (cmd.load) begin
			status_q <= cmd.status;
			ocount_q <= COUNT_W'(count_d);
			odata_q  <= cmd.item_valid ? cells_q[0] : '0;
			ovalid_q <= cmd.item_valid;
			olast_q  <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	assign out_status     = status_q;
	assign out_count      = ocount_q;
	assign out_data       = odata_q;
	assign out_item_valid = ovalid_q;
	assign out_last       = olast_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_INSERT) |-> ((count_q != CW'(CAPACITY)) && (idx <= count_q)))
		else $error("insert without room or past the back");

	a_remove_held: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.op == OP_REMOVE) || (cmd.op == OP_ROTATE)) |-> (idx <= tail && count_q != '0))
		else $error("remove or rotate on empty list or past the back");

endmodule

// File: rtl/positional_list_engine_core.sv
// top level of the positional list engine
// Bounded ordered list of signed 32-bit words, front at index 0, held in a chain
// of CAPACITY register cells. Each input transaction carries a request in
// s_tuser (add first/last/at, remove first/last/at, clear, dump) with the value
// and position in s_tdata. Every request other than dump answers with exactly
// one output transaction carrying status and the entry count after the request;
// a failed request (empty list, bad index, full) leaves the list untouched.
// Dump answers with one output transaction per entry, front to back, tlast on
// the final one; dump of an empty list gives a single empty_list result.
// Throughput: requests stream at one per clock while no dump runs and the
// consumer keeps up; the cell chain opens or closes a slot at any position in
// the cycle the request is accepted. A dump spends its accepting cycle loading
// the entry count, then gives one entry per cycle while the consumer keeps up,
// as the chain rotates its front entry into the single output register. The
// output register lets a new request be taken while an earlier result waits,
// as long as that result leaves in the same cycle. No clearing pass is needed
// after reset: the chain holds no valid entries until the count grows.
module positional_list_engine_core #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value [31:0], position [38:32], zero pad [39]
	input  logic [2:0]  s_tuser,   // req_type [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // count [6:0], item_data [38:7], zero pad [39]
	output logic [2:0]  m_tuser,   // status [1:0], item_valid [2]
	output logic        m_tlast    // last
);
	import ple_pkg::*;

	// count needs to hold CAPACITY itself
	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;
	req_t                      req;
	cmd_t                      cmd;
	logic [CW-1:0]             count;
	status_t                   out_status;
	logic [COUNT_W-1:0]        out_count;
	logic signed [VALUE_W-1:0] out_data;
	logic                      out_item_valid;

	// unpack the input transaction
	assign value    = s_tdata[VALUE_W-1:0];
	assign position = s_tdata[VALUE_W +: POS_W];
	assign req      = req_t'(s_tuser);

	ple_ctrl #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req      (req),
		.position (position),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.count    (count),
		.cmd      (cmd)
	);

	// cell chain plus result register
	ple_dpath #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.value          (value),
		.count          (count),
		.out_status     (out_status),
		.out_count      (out_count),
		.out_data       (out_data),
		.out_item_valid (out_item_valid),
		.out_last       (m_tlast)
	);

	// pack the output transaction
	assign m_tdata = {1'b0, out_data, out_count};
	assign m_tuser = {out_item_valid, out_status};

endmodule
